@@ hdl/bsa_pkg.sv @@
// shared constants, codes and types of the bitmap slot allocator
package bsa_pkg;

    localparam int WORD_COUNT = 4;
    localparam int WORD_BITS  = 64;
    localparam int IDX_W      = 16;
    localparam int GRANT_W    = 8;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PTR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int USE_W      = $clog2(WORD_COUNT + 1);
    localparam int CAPACITY   = WORD_COUNT * WORD_BITS;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [BIT_W-1:0]     bsel_t;
    typedef logic [USE_W-1:0]     use_t;

    typedef enum logic [2:0] {
        UOP_DISPATCH,
        UOP_GET,
        UOP_SET,
        UOP_SCAN,
        UOP_GRANT,
        UOP_FULL,
        UOP_NONE
    } uop_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] slot_index;
        logic             write_value;
    } cmd_word_t;

    typedef struct packed {
        logic               bit_value;
        logic [GRANT_W-1:0] granted_slot;
        logic [1:0]         status;
    } res_word_t;

    typedef struct packed {
        uop_t uop;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
        logic scan_free;
        logic scan_last;
    } stat_t;

endpackage

@@ hdl/bsa_if.sv @@
// valid/ready channels for command and result words
interface bsa_cmd_if import bsa_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bsa_res_if import bsa_pkg::*; ();
    logic      valid;
    logic      ready;
    res_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/bitmap_slot_allocator.sv @@
// bitmap slot allocator top level
// get and set run a dispatch step, then an execute step that waits for a free result register
// allocate runs dispatch, a scan step per bitmap word up to a free bit, then a grant or full step
// the scan pointer walks one word per cycle through the sequencer's scan step
// result register decouples the sides; a new word is taken while a result waits
// asynchronous reset clears the bitmap and word count at once, no clearing pass
module bitmap_slot_allocator import bsa_pkg::*; (
    input logic clk,
    input logic rst_n,
    bsa_cmd_if.sink   command,
    bsa_res_if.source result
);

    ctrl_t ctrl;
    stat_t stat;

    bsa_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (command.valid),
        .cmd_code  (command.payload.cmd),
        .stat      (stat),
        .cmd_ready (command.ready),
        .ctrl      (ctrl)
    );

    bsa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd_word  (command.payload),
        .res_ready (result.ready),
        .stat      (stat),
        .res_valid (result.valid),
        .res_word  (result.payload)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid && command.ready |=> !command.ready)
        else $error("sequencer still idle after taking a command word");

    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fire && ctrl.uop == UOP_SCAN && !stat.scan_free && !stat.scan_last
        |=> ctrl.uop == UOP_SCAN)
        else $error("scan left before the last word");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        command.ready |-> !(ctrl.fire && ctrl.uop != UOP_DISPATCH))
        else $error("datapath step fired while idle");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.status == ST_FULL
        |-> result.payload.granted_slot == '0 && !result.payload.bit_value)
        else $error("full result carries a slot or bit");

endmodule

@@ hdl/bsa_datapath.sv @@
// bitmap storage, scan logic and result register driven by the control word
module bsa_datapath import bsa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_t     ctrl,
    input  cmd_word_t cmd_word,
    input  logic      res_ready,
    output stat_t     stat,
    output logic      res_valid,
    output res_word_t res_word
);

    word_t     slot_reg [WORD_COUNT];
    word_t     slot_next [WORD_COUNT];
    use_t      use_reg, use_next;
    cmd_word_t cmd_reg, cmd_next;
    ptr_t      ptr_reg, ptr_next;
    bsel_t     bsel_reg, bsel_next;
    logic      res_valid_reg, res_valid_next;
    res_word_t res_word_reg, res_word_next;

    logic [IDX_W-1:0] idx_word;
    logic [IDX_W-1:0] grant_full;
    ptr_t             idx_ptr;
    bsel_t            idx_bit;
    bsel_t            first_zero;
    logic             over_cap;
    logic             beyond_use;
    word_t            cur_word;
    use_t             idx_cover;
    use_t             ptr_cover;

    always_comb
    begin
        idx_word   = IDX_W'(cmd_reg.slot_index / WORD_BITS);
        idx_bit    = BIT_W'(cmd_reg.slot_index % WORD_BITS);
        idx_ptr    = idx_word[PTR_W-1:0];
        over_cap   = {1'b0, cmd_reg.slot_index} >= (IDX_W + 1)'(CAPACITY);
        beyond_use = idx_word >= IDX_W'(use_reg);
        idx_cover  = USE_W'(idx_ptr) + USE_W'(1);
        ptr_cover  = USE_W'(ptr_reg) + USE_W'(1);
        cur_word   = slot_reg[ptr_reg];
        grant_full = IDX_W'(ptr_reg) * IDX_W'(WORD_BITS) + IDX_W'(bsel_reg);

        // lowest clear bit of the word under the scan pointer
        first_zero = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!cur_word[i])
            begin
                first_zero = BIT_W'(i);
            end
        end
    end

    assign stat.out_free  = !res_valid_reg || res_ready;
    assign stat.scan_free = ~&cur_word;
    assign stat.scan_last = ptr_reg == PTR_W'(WORD_COUNT - 1);

    always_comb
    begin
        slot_next      = slot_reg;
        use_next       = use_reg;
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        bsel_next      = bsel_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_word_next  = res_word_reg;

        if (ctrl.fire)
        begin
            unique case (ctrl.uop)
                UOP_DISPATCH:
                begin
                    cmd_next = cmd_word;
                    ptr_next = '0;
                end
                UOP_GET:
                begin
                    res_valid_next = 1'b1;
                    res_word_next  = '0;
                    if (over_cap || beyond_use)
                    begin
                        res_word_next.status = ST_RANGE;
                    end
                    else
                    begin
                        res_word_next.bit_value = slot_reg[idx_ptr][idx_bit];
                    end
                end
                UOP_SET:
                begin
                    res_valid_next = 1'b1;
                    res_word_next  = '0;
                    if (over_cap)
                    begin
                        res_word_next.status = ST_RANGE;
                    end
                    else
                    begin
                        slot_next[idx_ptr][idx_bit] = cmd_reg.write_value;
                        if (idx_cover > use_reg)
                        begin
                            use_next = idx_cover;
                        end
                    end
                end
                UOP_SCAN:
                begin
                    if (stat.scan_free)
                    begin
                        bsel_next = first_zero;
                    end
                    else if (!stat.scan_last)
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                UOP_GRANT:
                begin
                    slot_next[ptr_reg][bsel_reg] = 1'b1;
                    if (ptr_cover > use_reg)
                    begin
                        use_next = ptr_cover;
                    end
                    res_valid_next             = 1'b1;
                    res_word_next              = '0;
                    res_word_next.granted_slot = grant_full[GRANT_W-1:0];
                end
                UOP_FULL:
                begin
                    res_valid_next       = 1'b1;
                    res_word_next        = '0;
                    res_word_next.status = ST_FULL;
                end
                UOP_NONE:
                begin
                    res_valid_next = 1'b1;
                    res_word_next  = '0;
                end
                default:
                begin
                    res_valid_next = res_valid_reg && !res_ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                slot_reg[i] <= '0;
            end
            use_reg       <= '0;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            use_reg       <= use_next;
            ptr_reg       <= ptr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        bsel_reg     <= bsel_next;
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

@@ hdl/bsa_sequencer.sv @@
// micro-program counter, control store and jump logic
module bsa_sequencer import bsa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic [1:0] cmd_code,
    input  stat_t      stat,
    output logic       cmd_ready,
    output ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        UPC_IDLE,
        UPC_GET,
        UPC_SET,
        UPC_SCAN,
        UPC_FULL,
        UPC_GRANT,
        UPC_NONE
    } upc_t;

    typedef enum logic [1:0] {
        JMP_DISPATCH,
        JMP_RETURN,
        JMP_SCAN
    } jmp_t;

    typedef struct packed {
        uop_t uop;
        logic emit;
        jmp_t jmp;
        upc_t target;
    } uword_t;

    function automatic uword_t ucode(input upc_t a);
        uword_t w;
        unique case (a)
            UPC_IDLE:  w = '{uop: UOP_DISPATCH, emit: 1'b0, jmp: JMP_DISPATCH, target: UPC_IDLE};
            UPC_GET:   w = '{uop: UOP_GET,      emit: 1'b1, jmp: JMP_RETURN,   target: UPC_IDLE};
            UPC_SET:   w = '{uop: UOP_SET,      emit: 1'b1, jmp: JMP_RETURN,   target: UPC_IDLE};
            UPC_SCAN:  w = '{uop: UOP_SCAN,     emit: 1'b0, jmp: JMP_SCAN,     target: UPC_GRANT};
            UPC_FULL:  w = '{uop: UOP_FULL,     emit: 1'b1, jmp: JMP_RETURN,   target: UPC_IDLE};
            UPC_GRANT: w = '{uop: UOP_GRANT,    emit: 1'b1, jmp: JMP_RETURN,   target: UPC_IDLE};
            UPC_NONE:  w = '{uop: UOP_NONE,     emit: 1'b1, jmp: JMP_RETURN,   target: UPC_IDLE};
            default:   w = '{uop: UOP_DISPATCH, emit: 1'b0, jmp: JMP_DISPATCH, target: UPC_IDLE};
        endcase
        return w;
    endfunction

    function automatic upc_t entry(input logic [1:0] c);
        upc_t e;
        unique case (c)
            CMD_GET:   e = UPC_GET;
            CMD_SET:   e = UPC_SET;
            CMD_ALLOC: e = UPC_SCAN;
            default:   e = UPC_NONE;
        endcase
        return e;
    endfunction

    upc_t   upc_reg, upc_next;
    uword_t uw;

    always_comb
    begin
        uw        = ucode(upc_reg);
        cmd_ready = uw.jmp == JMP_DISPATCH;
        ctrl.uop  = uw.uop;
        if (uw.emit)
        begin
            ctrl.fire = stat.out_free;
        end
        else if (uw.jmp == JMP_DISPATCH)
        begin
            ctrl.fire = cmd_valid;
        end
        else
        begin
            ctrl.fire = 1'b1;
        end

        upc_next = upc_reg;
        unique case (uw.jmp)
            JMP_DISPATCH:
            begin
                if (cmd_valid)
                begin
                    upc_next = entry(cmd_code);
                end
            end
            JMP_RETURN:
            begin
                if (stat.out_free)
                begin
                    upc_next = uw.target;
                end
            end
            JMP_SCAN:
            begin
                if (stat.scan_free)
                begin
                    upc_next = uw.target;
                end
                else if (stat.scan_last)
                begin
                    upc_next = UPC_FULL;
                end
            end
            default:
            begin
                upc_next = UPC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
